>>> hw/rtl/rsu_pkg.sv
package rsu_pkg;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int OUT_W    = 40;
  localparam int SEL_W    = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]    stat_t;
  typedef logic        [SEL_W-1:0]    sel_t;

  // Statistic selector codes
  localparam sel_t STAT_COUNT  = 3'd0;
  localparam sel_t STAT_SUM    = 3'd1;
  localparam sel_t STAT_MEAN   = 3'd2;
  localparam sel_t STAT_STD    = 3'd3;
  localparam sel_t STAT_MAX    = 3'd4;
  localparam sel_t STAT_ARGMAX = 3'd5;

  localparam sel_t STAT_RESET  = STAT_MEAN;

endpackage

>>> hw/rtl/rsu_in_if.sv
interface rsu_in_if;

  logic              valid;
  logic              ready;
  logic              token_present;
  logic              is_numeric;
  logic              is_finite;
  rsu_pkg::sample_t  sample;
  logic              last_in_row;

  modport source (
    output valid, token_present, is_numeric, is_finite, sample, last_in_row,
    input  ready
  );

  modport sink (
    input  valid, token_present, is_numeric, is_finite, sample, last_in_row,
    output ready
  );

endinterface

>>> hw/rtl/rsu_out_if.sv
interface rsu_out_if;

  logic            valid;
  logic            ready;
  rsu_pkg::stat_t  stat_value;
  logic            is_nan;

  modport source (
    output valid, stat_value, is_nan,
    input  ready
  );

  modport sink (
    input  valid, stat_value, is_nan,
    output ready
  );

endinterface

>>> hw/rtl/row_statistics_unit.sv
// Row statistics unit.
// in_chan carries one token of a row per word (value, numeric and finite
// flags, row end mark); out_chan carries one word per row end: the statistic
// picked by the stat_select register (cfg_we / cfg_wdata) and a NaN flag.
// Each input word passes through the IDLE and ACC states: IDLE registers the
// sample and its square, ACC updates counts, sums and maximum. ready is high
// only while idle. At a row end a sequencer picks the statistic; mean runs a
// restoring divider, standard deviation one shift-add multiplier, the shared
// divider twice and a bit-serial square root. The multiplier takes W-bit
// operands and the divider 2W-bit dividends, with W = 24 + clog2(N+1)
// (N = MAX_TOKENS, W = 35 at the default).
// The result sits in an output register, so tokens of the next row are taken
// while it waits; a further row end waits until that word has been taken.
// Reset (synchronous, rst_n low) clears all row state and the output valid,
// and sets stat_select to mean.
module row_statistics_unit #(
  parameter int MAX_TOKENS = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  rsu_pkg::sel_t   cfg_wdata,
  rsu_in_if.sink          in_chan,
  rsu_out_if.source       out_chan
);

  localparam int SW      = rsu_pkg::SAMPLE_W;
  localparam int OW      = rsu_pkg::OUT_W;
  localparam int CNT_W   = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W   = $clog2(MAX_TOKENS);
  localparam int SUM_W   = SW + CNT_W;
  localparam int PROD_W  = 2 * SW;
  localparam int SQ_W    = 2 * SW - 2 + CNT_W;
  localparam int DW      = 2 * SUM_W;
  localparam int CW      = $clog2(DW + 1);
  localparam int SQ_HALF = (SQ_W + 1) / 2;
  localparam int SQ_TOP  = 2 * (SQ_HALF - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_POST = 3'd5;
  localparam logic [2:0] S_SQRT = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  // What the divider result is for
  localparam logic [1:0] JOB_MEAN = 2'd0;
  localparam logic [1:0] JOB_Q    = 2'd1;
  localparam logic [1:0] JOB_V    = 2'd2;

  logic [2:0]               state_r, state_nxt;
  logic [1:0]               job_r, job_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  rsu_pkg::sel_t            sel_r, sel_nxt;

  // Registered input word
  logic                     tok_r, tok_nxt;
  logic                     numeric_r, numeric_nxt;
  logic                     fin_r, fin_nxt;
  logic                     last_r, last_nxt;
  logic signed [SW-1:0]     samp_r, samp_nxt;
  logic [PROD_W-1:0]        sqp_r, sqp_nxt;
  logic signed [PROD_W-1:0] in_prod;

  // Row accumulators
  logic [IDX_W-1:0]         tidx_r, tidx_nxt;
  logic [CNT_W-1:0]         ncnt_r, ncnt_nxt;
  logic [CNT_W-1:0]         fcnt_r, fcnt_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]          sumsq_r, sumsq_nxt;
  logic signed [SW-1:0]     peak_r, peak_nxt;
  logic [IDX_W-1:0]         pidx_r, pidx_nxt;
  logic                     pseen_r, pseen_nxt;

  // Shared arithmetic
  logic [DW-1:0]            div_num_r, div_num_nxt;
  logic [CNT_W-1:0]         div_rem_r, div_rem_nxt;
  logic [CNT_W-1:0]         div_den_r, div_den_nxt;
  logic [DW-1:0]            mul_a_r, mul_a_nxt;
  logic [SUM_W-1:0]         mul_b_r, mul_b_nxt;
  logic [SQ_W-1:0]          sq_v_r, sq_v_nxt;
  logic [SQ_W-1:0]          sq_res_r, sq_res_nxt;
  logic [SQ_W-1:0]          sq_bit_r, sq_bit_nxt;

  // Result and output register
  logic signed [OW-1:0]     res_val_r, res_val_nxt;
  logic                     res_nan_r, res_nan_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [OW-1:0]     out_val_r, out_val_nxt;
  logic                     out_nan_r, out_nan_nxt;

  // Datapath helpers
  logic [SUM_W-1:0]         mag;
  logic [CNT_W:0]           rem_sh;
  logic [CNT_W:0]           den_ext;
  logic                     q_bit;
  logic [CNT_W:0]           rem_new;
  logic signed [SUM_W:0]    mean_s;
  logic [DW-1:0]            ss_ext;
  logic [DW-1:0]            v_full;
  logic [SQ_W:0]            sq_t;
  logic                     sq_ge;
  logic [SQ_W:0]            sq_diff;
  logic [SQ_W-1:0]          sq_res_step;
  logic                     in_acc;

  assign in_chan.ready       = (state_r == S_IDLE);
  assign in_acc              = in_chan.valid && (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.stat_value = out_val_r;
  assign out_chan.is_nan     = out_nan_r;

  assign in_prod = PROD_W'(in_chan.sample) * PROD_W'(in_chan.sample);

  // Magnitude of the running sum
  assign mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  // One restoring division step
  assign rem_sh  = {div_rem_r, div_num_r[DW-1]};
  assign den_ext = {1'b0, div_den_r};
  assign q_bit   = (rem_sh >= den_ext);
  assign rem_new = q_bit ? (rem_sh - den_ext) : rem_sh;

  // Signed mean from the magnitude quotient
  assign mean_s = sum_r[SUM_W-1] ? -$signed({1'b0, div_num_r[SUM_W-1:0]})
                                 :  $signed({1'b0, div_num_r[SUM_W-1:0]});

  // Variance numerator, clamped at zero
  assign ss_ext = DW'(sumsq_r);
  assign v_full = (ss_ext > div_num_r) ? (ss_ext - div_num_r) : '0;

  // One square root step
  assign sq_t        = {1'b0, sq_res_r} + {1'b0, sq_bit_r};
  assign sq_ge       = ({1'b0, sq_v_r} >= sq_t);
  assign sq_diff     = {1'b0, sq_v_r} - sq_t;
  assign sq_res_step = sq_ge ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    tok_nxt       = tok_r;
    numeric_nxt   = numeric_r;
    fin_nxt       = fin_r;
    last_nxt      = last_r;
    samp_nxt      = samp_r;
    sqp_nxt       = sqp_r;
    tidx_nxt      = tidx_r;
    ncnt_nxt      = ncnt_r;
    fcnt_nxt      = fcnt_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    peak_nxt      = peak_r;
    pidx_nxt      = pidx_r;
    pseen_nxt     = pseen_r;
    div_num_nxt   = div_num_r;
    div_rem_nxt   = div_rem_r;
    div_den_nxt   = div_den_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    sq_v_nxt      = sq_v_r;
    sq_res_nxt    = sq_res_r;
    sq_bit_nxt    = sq_bit_r;
    res_val_nxt   = res_val_r;
    res_nan_nxt   = res_nan_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_nan_nxt   = out_nan_r;

    if (cfg_we) begin
      sel_nxt = cfg_wdata;
    end

    // Output word taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          tok_nxt     = in_chan.token_present;
          numeric_nxt = in_chan.is_numeric;
          fin_nxt     = in_chan.is_finite;
          last_nxt    = in_chan.last_in_row;
          samp_nxt    = in_chan.sample;
          sqp_nxt     = $unsigned(in_prod);
          state_nxt   = S_ACC;
        end
      end

      // Fold the registered word into the row
      S_ACC: begin
        if (tok_r) begin
          if (numeric_r) begin
            if (ncnt_r < CNT_W'(MAX_TOKENS)) begin
              ncnt_nxt = ncnt_r + 1'b1;
            end
            if (fin_r && (fcnt_r < CNT_W'(MAX_TOKENS))) begin
              fcnt_nxt  = fcnt_r + 1'b1;
              sum_nxt   = sum_r + SUM_W'(samp_r);
              sumsq_nxt = sumsq_r + SQ_W'(sqp_r);
              if (!pseen_r || (samp_r > peak_r)) begin
                peak_nxt  = samp_r;
                pidx_nxt  = tidx_r;
                pseen_nxt = 1'b1;
              end
            end
          end
          if (tidx_r < IDX_W'(MAX_TOKENS - 1)) begin
            tidx_nxt = tidx_r + 1'b1;
          end
        end
        state_nxt = last_r ? S_EVAL : S_IDLE;
      end

      // Row end: pick the statistic
      S_EVAL: begin
        res_val_nxt = '0;
        res_nan_nxt = 1'b0;
        state_nxt   = S_OUT;
        priority if (sel_r == rsu_pkg::STAT_COUNT) begin
          res_val_nxt = OW'(ncnt_r);
        end else if (sel_r > rsu_pkg::STAT_ARGMAX) begin
          res_val_nxt = '0;
        end else if (fcnt_r == '0) begin
          res_nan_nxt = 1'b1;
        end else if (sel_r == rsu_pkg::STAT_SUM) begin
          res_val_nxt = OW'(sum_r);
        end else if (sel_r == rsu_pkg::STAT_MEAN) begin
          div_num_nxt = DW'(mag);
          div_rem_nxt = '0;
          div_den_nxt = fcnt_r;
          cnt_nxt     = CW'(DW);
          job_nxt     = JOB_MEAN;
          state_nxt   = S_DIV;
        end else if (sel_r == rsu_pkg::STAT_STD) begin
          if (fcnt_r >= CNT_W'(2)) begin
            div_num_nxt = '0;
            mul_a_nxt   = DW'(mag);
            mul_b_nxt   = mag;
            cnt_nxt     = CW'(SUM_W);
            state_nxt   = S_MUL;
          end
        end else if (sel_r == rsu_pkg::STAT_MAX) begin
          res_val_nxt = OW'(peak_r);
        end else begin
          res_val_nxt = OW'(pidx_r);
        end
      end

      // Shift-add square of the sum magnitude
      S_MUL: begin
        if (mul_b_r[0]) begin
          div_num_nxt = div_num_r + mul_a_r;
        end
        mul_a_nxt = mul_a_r << 1;
        mul_b_nxt = mul_b_r >> 1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          div_rem_nxt = '0;
          div_den_nxt = fcnt_r;
          cnt_nxt     = CW'(DW);
          job_nxt     = JOB_Q;
          state_nxt   = S_DIV;
        end
      end

      // Restoring divider, one quotient bit a cycle
      S_DIV: begin
        div_rem_nxt = rem_new[CNT_W-1:0];
        div_num_nxt = {div_num_r[DW-2:0], q_bit};
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = S_POST;
        end
      end

      S_POST: begin
        unique case (job_r)
          JOB_MEAN: begin
            res_val_nxt = OW'(mean_s);
            state_nxt   = S_OUT;
          end
          JOB_Q: begin
            div_num_nxt = DW'(v_full[SQ_W-1:0]);
            div_rem_nxt = '0;
            div_den_nxt = fcnt_r - 1'b1;
            cnt_nxt     = CW'(DW);
            job_nxt     = JOB_V;
            state_nxt   = S_DIV;
          end
          default: begin
            sq_v_nxt   = div_num_r[SQ_W-1:0];
            sq_res_nxt = '0;
            sq_bit_nxt = SQ_W'(1) << SQ_TOP;
            cnt_nxt    = CW'(SQ_HALF);
            state_nxt  = S_SQRT;
          end
        endcase
      end

      // Floor square root, two radicand bits a cycle
      S_SQRT: begin
        if (sq_ge) begin
          sq_v_nxt = sq_diff[SQ_W-1:0];
        end
        sq_res_nxt = sq_res_step;
        sq_bit_nxt = sq_bit_r >> 2;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          res_val_nxt = OW'(sq_res_step);
          state_nxt   = S_OUT;
        end
      end

      // Hand the result to the output register and clear the row
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_nan_nxt   = res_nan_r;
          tidx_nxt      = '0;
          ncnt_nxt      = '0;
          fcnt_nxt      = '0;
          sum_nxt       = '0;
          sumsq_nxt     = '0;
          peak_nxt      = '0;
          pidx_nxt      = '0;
          pseen_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= JOB_MEAN;
      cnt_r       <= '0;
      sel_r       <= rsu_pkg::STAT_RESET;
      tidx_r      <= '0;
      ncnt_r      <= '0;
      fcnt_r      <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      peak_r      <= '0;
      pidx_r      <= '0;
      pseen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      tidx_r      <= tidx_nxt;
      ncnt_r      <= ncnt_nxt;
      fcnt_r      <= fcnt_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      peak_r      <= peak_nxt;
      pidx_r      <= pidx_nxt;
      pseen_r     <= pseen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tok_r     <= tok_nxt;
    numeric_r <= numeric_nxt;
    fin_r     <= fin_nxt;
    last_r    <= last_nxt;
    samp_r    <= samp_nxt;
    sqp_r     <= sqp_nxt;
    div_num_r <= div_num_nxt;
    div_rem_r <= div_rem_nxt;
    div_den_r <= div_den_nxt;
    mul_a_r   <= mul_a_nxt;
    mul_b_r   <= mul_b_nxt;
    sq_v_r    <= sq_v_nxt;
    sq_res_r  <= sq_res_nxt;
    sq_bit_r  <= sq_bit_nxt;
    res_val_r <= res_val_nxt;
    res_nan_r <= res_nan_nxt;
    out_val_r <= out_val_nxt;
    out_nan_r <= out_nan_nxt;
  end

endmodule
